// ----- hdl/hashed_word_counter_macros.svh -----
// assertion macros for the hashed word counter
`ifndef HASHED_WORD_COUNTER_MACROS_SVH
`define HASHED_WORD_COUNTER_MACROS_SVH

// implication checked every clock, off while reset is high
`define HWC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication checked every clock, off while reset is high
`define HWC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- hdl/hwc_pkg.sv -----
package hwc_pkg;

   localparam int NumBuckets  = 1024;
   localparam int Ways        = 4;
   localparam int WordBytes   = 48;
   localparam int MaxChars    = WordBytes - 1;
   localparam int Chunks      = (WordBytes + 7) / 8;
   localparam int Entries     = NumBuckets * Ways;
   localparam int BucketBits  = $clog2(NumBuckets);
   localparam int WayBits     = (Ways > 1) ? $clog2(Ways) : 1;
   localparam int ChunkBits   = (Chunks > 1) ? $clog2(Chunks) : 1;
   localparam int EntryBits   = $clog2(Entries);
   localparam int KeyAddrBits = $clog2(Entries * Chunks);
   localparam int LenBits     = $clog2(WordBytes);
   localparam int BufBits     = $clog2(WordBytes);
   localparam int BytesPerChunk = 8;

   localparam logic [31:0] HashSeed = 32'd131;
   localparam logic [31:0] HashMask = 32'h7FFF_FFFF;
   localparam logic [31:0] CountMax = 32'hFFFF_FFFF;

   localparam logic CmdCount = 1'b0;
   localparam logic CmdQuery = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_COLLECT,
      ST_BUCKET,
      ST_PROBE_RD,
      ST_PROBE_CMP,
      ST_CHUNK_RD,
      ST_CHUNK_CMP,
      ST_WRITE_CNT,
      ST_WRITE_KEY,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic [31:0] word_count;
      logic        was_found;
      logic        bucket_full;
      logic        word_too_long;
   } result_type;

endpackage

// ----- hdl/hwc_stream_if.sv -----
interface hwc_stream_if #(parameter int Width = 1);
   logic             valid;
   logic             ready;
   logic [Width-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/hwc_ram.sv -----
module hwc_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- hdl/hwc_word_buf.sv -----
module hwc_word_buf (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         take,
   input  logic [7:0]                   char_code,
   input  logic                         clear,
   input  logic [hwc_pkg::ChunkBits-1:0] chunk_sel,
   output logic [63:0]                  chunk,
   output logic [hwc_pkg::LenBits-1:0]  length,
   output logic [31:0]                  hash,
   output logic                         overflow
);
   import hwc_pkg::*;

   logic [63:0]        buf_ff [Chunks];
   logic [LenBits-1:0] length_ff, length_in;
   logic [31:0]        hash_ff, hash_in;
   logic               overflow_ff, overflow_in;
   logic [31:0]        prod;

   assign prod = hash_ff * HashSeed;

   always_comb begin
      length_in   = length_ff;
      hash_in     = hash_ff;
      overflow_in = overflow_ff;
      if (clear) begin
         length_in   = '0;
         hash_in     = '0;
         overflow_in = 1'b0;
      end else if (take && char_code != 8'd0) begin
         if (length_ff < LenBits'(MaxChars)) begin
            length_in = length_ff + 1'b1;
            hash_in   = prod + {24'd0, char_code};
         end else begin
            overflow_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff   <= '0;
         hash_ff     <= '0;
         overflow_ff <= 1'b0;
      end else begin
         length_ff   <= length_in;
         hash_ff     <= hash_in;
         overflow_ff <= overflow_in;
      end
   end

   // one 64-bit register per chunk, zero beyond the length
   always_ff @(posedge clock) begin
      if (take && !clear && char_code != 8'd0 && length_ff < LenBits'(MaxChars)) begin
         buf_ff[length_ff[LenBits-1:3]][length_ff[2:0]*8 +: 8] <= char_code;
      end
   end

   always_comb begin
      chunk = buf_ff[chunk_sel];
      for (int b = 0; b < BytesPerChunk; b++) begin
         if ({chunk_sel, 3'(b)} >= length_ff) begin
            chunk[b*8 +: 8] = 8'd0;
         end
      end
   end

   assign length   = length_ff;
   assign hash     = hash_ff;
   assign overflow = overflow_ff;
endmodule

// ----- hdl/hashed_word_counter.sv -----
// channel | dir | payload
// req     | in  | cmd, char_code, last_char
// rsp     | out | word_count, was_found, bucket_full, word_too_long
// a non-last character is taken in ST_COLLECT; a word end passes through ST_BUCKET,
// ST_PROBE_RD and ST_PROBE_CMP per way for the length check, ST_CHUNK_RD and ST_CHUNK_CMP
// per key chunk compared, ST_WRITE_KEY for an insert and ST_RESULT for the response
// after reset a clearing pass writes every valid bit, one entry per cycle
// req is held off during the clearing pass, while a word is probed and until its
// response is taken
`include "hashed_word_counter_macros.svh"
module hashed_word_counter (
   input logic   clock,
   input logic   reset,
   hwc_stream_if.sink   req,
   hwc_stream_if.source rsp
);
   import hwc_pkg::*;

   logic req_cmd, req_last_char;
   logic [7:0] req_char_code;
   assign req_cmd       = req.data[0];
   assign req_char_code = req.data[8:1];
   assign req_last_char = req.data[9];

   state_type state_ff, state_in;
   logic cmd_ff, cmd_in;
   logic [WayBits-1:0] way_ff, way_in;
   logic [ChunkBits-1:0] chunk_ff, chunk_in;
   logic have_free_ff, have_free_in;
   logic [WayBits-1:0] free_ff, free_in;
   logic [BucketBits-1:0] bucket_ff, bucket_in;
   result_type res_ff, res_in;
   logic [EntryBits-1:0] clr_ff, clr_in;
   logic [EntryBits-1:0] valid_rd_idx;
   logic [EntryBits-1:0] valid_wr_idx;
   logic valid_we, valid_wd, valid_rd;

   logic take, clear;
   logic [63:0] chunk;
   logic [LenBits-1:0] length;
   logic [31:0] hash;
   logic overflow;

   logic [EntryBits-1:0] entry;
   logic [KeyAddrBits-1:0] key_addr;
   logic key_we, len_we, cnt_we;
   logic [63:0] key_rd;
   logic [LenBits-1:0] len_rd;
   logic [31:0] cnt_rd, cnt_wd;
   logic last_way, last_chunk;

   assign take = req.valid && req.ready;

   hwc_word_buf u_buf (
      .clock, .reset, .take, .char_code(req_char_code), .clear,
      .chunk_sel(chunk_ff), .chunk, .length, .hash, .overflow
   );

   assign entry = EntryBits'({bucket_ff, {WayBits{1'b0}}}) + EntryBits'(way_ff);
   assign key_addr = KeyAddrBits'(32'(entry) * Chunks + 32'(chunk_ff));
   assign valid_rd_idx = entry;
   assign valid_we     = len_we || (state_ff == ST_CLEAR);
   assign valid_wd     = (state_ff != ST_CLEAR);
   assign valid_wr_idx = (state_ff == ST_CLEAR) ? clr_ff : entry;

   hwc_ram #(.Width(64), .Depth(Entries * Chunks)) u_key (
      .clock, .wr_en(key_we), .wr_addr(key_addr), .wr_data(chunk),
      .rd_addr(key_addr), .rd_data(key_rd)
   );
   hwc_ram #(.Width(LenBits), .Depth(Entries)) u_len (
      .clock, .wr_en(len_we), .wr_addr(entry), .wr_data(length),
      .rd_addr(entry), .rd_data(len_rd)
   );
   hwc_ram #(.Width(32), .Depth(Entries)) u_cnt (
      .clock, .wr_en(cnt_we), .wr_addr(entry), .wr_data(cnt_wd),
      .rd_addr(entry), .rd_data(cnt_rd)
   );
   hwc_ram #(.Width(1), .Depth(Entries)) u_valid (
      .clock, .wr_en(valid_we), .wr_addr(valid_wr_idx), .wr_data(valid_wd),
      .rd_addr(valid_rd_idx), .rd_data(valid_rd)
   );

   assign last_way   = (32'(way_ff) == Ways - 1);
   assign last_chunk = (32'(chunk_ff) == Chunks - 1);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      way_in       = way_ff;
      chunk_in     = chunk_ff;
      have_free_in = have_free_ff;
      free_in      = free_ff;
      bucket_in    = bucket_ff;
      res_in       = res_ff;
      clr_in       = clr_ff;
      clear        = 1'b0;
      key_we       = 1'b0;
      len_we       = 1'b0;
      cnt_we       = 1'b0;
      cnt_wd       = 32'd1;
      req.ready    = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (32'(clr_ff) == Entries - 1) begin
               state_in = ST_COLLECT;
            end
         end
         ST_COLLECT: begin
            req.ready = 1'b1;
            if (take && req_last_char) begin
               cmd_in       = req_cmd;
               way_in       = '0;
               chunk_in     = '0;
               have_free_in = 1'b0;
               res_in       = '0;
               state_in     = ST_BUCKET;
            end
         end
         ST_BUCKET: begin
            // overflow and hash are final in this state, registered with the last character
            bucket_in = BucketBits'(32'(hash & HashMask) % NumBuckets);
            if (overflow) begin
               res_in.word_too_long = 1'b1;
               state_in = ST_RESULT;
            end else begin
               state_in = ST_PROBE_RD;
            end
         end
         ST_PROBE_RD: begin
            state_in = ST_PROBE_CMP;
         end
         ST_PROBE_CMP: begin
            chunk_in = '0;
            if (valid_rd) begin
               if (len_rd == length) begin
                  state_in = ST_CHUNK_RD;
               end else if (last_way) begin
                  state_in = ST_WRITE_KEY;
               end else begin
                  way_in   = way_ff + 1'b1;
                  state_in = ST_PROBE_RD;
               end
            end else begin
               if (!have_free_ff) begin
                  have_free_in = 1'b1;
                  free_in      = way_ff;
               end
               if (last_way) begin
                  state_in = ST_WRITE_KEY;
               end else begin
                  way_in   = way_ff + 1'b1;
                  state_in = ST_PROBE_RD;
               end
            end
         end
         ST_CHUNK_RD: begin
            state_in = ST_CHUNK_CMP;
         end
         ST_CHUNK_CMP: begin
            if (key_rd != chunk) begin
               chunk_in = '0;
               if (last_way) begin
                  state_in = ST_WRITE_KEY;
               end else begin
                  way_in   = way_ff + 1'b1;
                  state_in = ST_PROBE_RD;
               end
            end else if (!last_chunk) begin
               chunk_in = chunk_ff + 1'b1;
               state_in = ST_CHUNK_RD;
            end else begin
               // hit; count read data valid (entry unchanged)
               res_in.was_found = 1'b1;
               state_in = ST_WRITE_CNT;
            end
         end
         ST_WRITE_CNT: begin
            if (cmd_ff == CmdCount && cnt_rd != CountMax) begin
               cnt_wd = cnt_rd + 32'd1;
               cnt_we = 1'b1;
               res_in.word_count = cnt_rd + 32'd1;
            end else begin
               res_in.word_count = cnt_rd;
            end
            state_in = ST_RESULT;
         end
         ST_WRITE_KEY: begin
            // miss path
            if (cmd_ff == CmdQuery) begin
               state_in = ST_RESULT;
            end else if (!have_free_ff) begin
               res_in.bucket_full = 1'b1;
               state_in = ST_RESULT;
            end else begin
               way_in = free_ff;
               if (way_ff == free_ff) begin
                  key_we = 1'b1;
                  if (last_chunk) begin
                     len_we = 1'b1;
                     cnt_we = 1'b1;
                     res_in.word_count = 32'd1;
                     state_in = ST_RESULT;
                  end else begin
                     chunk_in = chunk_ff + 1'b1;
                  end
               end
            end
         end
         ST_RESULT: begin
            clear = 1'b1;
            if (rsp.ready) begin
               state_in = ST_COLLECT;
            end
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      way_ff       <= way_in;
      chunk_ff     <= chunk_in;
      have_free_ff <= have_free_in;
      free_ff      <= free_in;
      bucket_ff    <= bucket_in;
      res_ff       <= res_in;
   end

   assign rsp.valid = (state_ff == ST_RESULT);
   assign rsp.data  = res_ff;

   `HWC_ASSERT_IMP(a_ready_only_collect, clock, reset, req.ready, state_ff == ST_COLLECT)
   `HWC_ASSERT_IMP(a_flags_exclusive, clock, reset, rsp.valid,
      !(res_ff.bucket_full && res_ff.was_found))
   `HWC_ASSERT_IMP(a_too_long_alone, clock, reset, rsp.valid && res_ff.word_too_long,
      res_ff.word_count == 32'd0 && !res_ff.was_found && !res_ff.bucket_full)
   `HWC_ASSERT_NXT(a_rsp_leaves, clock, reset, rsp.valid && rsp.ready,
      state_ff == ST_COLLECT)
endmodule
